>>> sv/rhs_pkg.sv
// shared constants, codes and tables of the road harmonic synthesizer
package rhs_pkg;

    // request op codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_WAVE  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // cordic datapath
    localparam int CORDIC_STEPS = 30;
    localparam int CW = 33;
    localparam logic signed [CW-1:0] K_Q30 = 33'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q20 = 33'sd6588397;

    // shared multiplier operand and product widths
    localparam int MA_W = 41;
    localparam int MB_W = 33;
    localparam int MP_W = MA_W + MB_W;

    // accumulator widths and output limits
    localparam int HACC_W = 36;
    localparam int VACC_W = 48;
    localparam logic signed [HACC_W-1:0] HEIGHT_LIM = 36'sd16777216;
    localparam logic signed [VACC_W-1:0] VEL_MAX = 48'sd549755813887;
    localparam logic signed [VACC_W-1:0] VEL_MIN = -48'sd549755813888;

    typedef logic signed [CW-1:0] cordic_word_t;

    // arctangent of 2^-i in q30 radians
    function automatic cordic_word_t atan_q30(input logic [4:0] i);
        cordic_word_t v;
        unique case (i)
            5'd0:  v = 33'sd843314857;
            5'd1:  v = 33'sd497837829;
            5'd2:  v = 33'sd263043837;
            5'd3:  v = 33'sd133525159;
            5'd4:  v = 33'sd67021687;
            5'd5:  v = 33'sd33543516;
            5'd6:  v = 33'sd16775851;
            5'd7:  v = 33'sd8388437;
            5'd8:  v = 33'sd4194283;
            5'd9:  v = 33'sd2097149;
            5'd10: v = 33'sd1048576;
            5'd11: v = 33'sd524288;
            5'd12: v = 33'sd262144;
            5'd13: v = 33'sd131072;
            5'd14: v = 33'sd65536;
            5'd15: v = 33'sd32768;
            5'd16: v = 33'sd16384;
            5'd17: v = 33'sd8192;
            5'd18: v = 33'sd4096;
            5'd19: v = 33'sd2048;
            5'd20: v = 33'sd1024;
            5'd21: v = 33'sd512;
            5'd22: v = 33'sd256;
            5'd23: v = 33'sd128;
            5'd24: v = 33'sd64;
            5'd25: v = 33'sd32;
            5'd26: v = 33'sd16;
            5'd27: v = 33'sd8;
            5'd28: v = 33'sd4;
            5'd29: v = 33'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/rhs_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
module rhs_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rhs_pkg::cordic_word_t z_in,
    output logic                  done,
    output rhs_pkg::cordic_word_t x_out,
    output rhs_pkg::cordic_word_t y_out
);
    import rhs_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [4:0]   i_reg, i_next;
    cordic_word_t x_reg, x_next;
    cordic_word_t y_reg, y_next;
    cordic_word_t z_reg, z_next;
    cordic_word_t dx, dy;

    // shifted operands for the current step
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    // step sequencing and rotation toward zero residual angle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            x_next    = K_Q30;
            y_next    = '0;
            z_next    = z_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_q30(i_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_q30(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

>>> sv/road_harmonic_synthesizer.sv
// top level of the per-wheel road harmonic synthesizer
// One request at a time. A clear or a refused add goes straight to the result; an accepted
// add runs the 40-step restoring divider that forms speed / wavelength; an evaluate runs,
// for each of the n stored harmonics, the 30-step cordic and the one shared multiplier
// that every product of a harmonic goes through. A finished result waits in the output
// register while the next request is taken. vehicle_speed is written through
// cfg_we / cfg_wdata.
module road_harmonic_synthesizer #(
    parameter int WHEELS        = 4,
    parameter int MAX_HARMONICS = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,      // vehicle_speed
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // wheel, component_amplitude,
                                         // component_wavelength, component_phase,
                                         // sample_time, zero fill
    input  logic [1:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // height, vertical_velocity, status, zero fill
);
    import rhs_pkg::*;

    localparam int WB = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int SB = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CB = $clog2(MAX_HARMONICS + 1);
    localparam int DEPTH = WHEELS * MAX_HARMONICS;
    localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_LD   = 4'd4;
    localparam logic [3:0] S_MFT  = 4'd5;
    localparam logic [3:0] S_MZ   = 4'd6;
    localparam logic [3:0] S_CST  = 4'd7;
    localparam logic [3:0] S_CW   = 4'd8;
    localparam logic [3:0] S_MH   = 4'd9;
    localparam logic [3:0] S_MAF  = 4'd10;
    localparam logic [3:0] S_MTP  = 4'd11;
    localparam logic [3:0] S_MV   = 4'd12;
    localparam logic [3:0] S_ACC  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]  state_reg, state_next;
    logic [15:0] speed_reg;

    // request fields
    logic [1:0]  op_in, wheel_in;
    logic [19:0] amp_in;
    logic [31:0] wl_in, t_in;
    logic [15:0] ph_in;
    logic        acc;

    // working registers
    logic [1:0]  wheel_reg, wheel_next;
    logic [19:0] amp_reg, amp_next;
    logic [31:0] wl_reg, wl_next;
    logic [15:0] ph_reg, ph_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] f_reg, f_next;
    logic [1:0]  status_reg, status_next;
    logic [CB-1:0] n_reg, n_next;
    logic [CB-1:0] k_reg, k_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [39:0] quo_reg, quo_next;
    logic [1:0]  quad_reg, quad_next;
    cordic_word_t cos_reg, cos_next;
    cordic_word_t sin_reg, sin_next;
    logic signed [HACC_W-1:0] hacc_reg, hacc_next;
    logic signed [VACC_W-1:0] vacc_reg, vacc_next;
    logic signed [MP_W-1:0]   prod_reg;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;

    // per-wheel fill counts
    logic [CB-1:0] cnt_reg [WHEELS];
    logic          cnt_clr, cnt_inc;
    logic [WB-1:0] widx;

    // harmonic store: frequency, phase, amplitude
    logic [67:0]   mem [DEPTH];
    logic [67:0]   rd_q;
    logic          mem_we;
    logic [AB-1:0] wr_addr, rd_addr;
    logic [31:0]   f_sat;

    // cordic interface
    logic         cor_start, cor_done;
    cordic_word_t cor_x, cor_y, cor_z;

    // angle path
    logic [31:0] u_ang;
    logic [32:0] div_trial;
    logic [32:0] div_shift;

    // output register
    logic        mvalid_reg;
    logic [25:0] oh_reg;
    logic [39:0] ov_reg;
    logic [1:0]  os_reg;
    logic signed [HACC_W-1:0] h_clamp;
    logic signed [VACC_W-1:0] v_clamp;

    // request unpacking
    assign op_in    = s_axis_tuser;
    assign wheel_in = s_axis_tdata[1:0];
    assign amp_in   = s_axis_tdata[21:2];
    assign wl_in    = s_axis_tdata[53:22];
    assign ph_in    = s_axis_tdata[69:54];
    assign t_in     = s_axis_tdata[101:70];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    assign widx    = WB'(wheel_reg);
    assign wr_addr = AB'(AB'(widx) * AB'(MAX_HARMONICS)) + AB'(cnt_reg[widx]);
    assign rd_addr = AB'(AB'(widx) * AB'(MAX_HARMONICS)) + AB'(k_reg[SB-1:0]);
    assign f_sat   = (|quo_reg[39:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];

    // divider step
    assign div_shift = {rem_reg[31:0], quo_reg[39]};
    assign div_trial = div_shift - {1'b0, wl_reg};

    // phase angle in turns, truncated to the angle resolution
    assign u_ang = (prod_reg[31:0] + {ph_reg, 16'h0}) & ANG_MASK;
    assign cor_z = {2'b00, prod_reg[60:30]};

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_MFT:
            begin
                mul_a = {9'b0, f_reg};
                mul_b = {1'b0, t_reg};
            end
            S_MZ:
            begin
                mul_a = {11'b0, u_ang[29:0]};
                mul_b = HALF_PI_Q30;
            end
            S_MH:
            begin
                mul_a = {{(MA_W-CW){sin_reg[CW-1]}}, sin_reg};
                mul_b = {13'b0, amp_reg};
            end
            S_MAF:
            begin
                mul_a = {9'b0, f_reg};
                mul_b = {13'b0, amp_reg};
            end
            S_MTP:
            begin
                mul_a = {1'b0, prod_reg[51:12]};
                mul_b = TWO_PI_Q20;
            end
            S_MV:
            begin
                mul_a = {6'b0, prod_reg[62:28]};
                mul_b = cos_reg >>> 8;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product register of the shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
    end

    rhs_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .z_in  (cor_z),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y)
    );

    // output clamping
    always_comb
    begin
        priority if (hacc_reg > HEIGHT_LIM)
            h_clamp = HEIGHT_LIM;
        else if (hacc_reg < -HEIGHT_LIM)
            h_clamp = -HEIGHT_LIM;
        else
            h_clamp = hacc_reg;
        priority if (vacc_reg > VEL_MAX)
            v_clamp = VEL_MAX;
        else if (vacc_reg < VEL_MIN)
            v_clamp = VEL_MIN;
        else
            v_clamp = vacc_reg;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        wheel_next  = wheel_reg;
        amp_next    = amp_reg;
        wl_next     = wl_reg;
        ph_next     = ph_reg;
        t_next      = t_reg;
        f_next      = f_reg;
        status_next = status_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        dcnt_next   = dcnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        quad_next   = quad_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;
        hacc_next   = hacc_reg;
        vacc_next   = vacc_reg;
        cnt_clr     = 1'b0;
        cnt_inc     = 1'b0;
        mem_we      = 1'b0;
        cor_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    wheel_next  = wheel_in;
                    amp_next    = amp_in;
                    wl_next     = wl_in;
                    ph_next     = ph_in;
                    t_next      = t_in;
                    status_next = ST_OK;
                    hacc_next   = '0;
                    vacc_next   = '0;
                    k_next      = '0;
                    state_next  = S_DONE;
                    if (op_in == OP_CLEAR)
                    begin
                        cnt_clr = 1'b1;
                    end
                    else if (op_in == OP_ADD)
                    begin
                        if (wl_in == 32'h0)
                            status_next = ST_BAD_WAVE;
                        else if (32'(wheel_in) >= WHEELS)
                            status_next = ST_FULL;
                        else if (cnt_reg[WB'(wheel_in)] >= CB'(MAX_HARMONICS))
                            status_next = ST_FULL;
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = {speed_reg, 24'h0};
                            dcnt_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                    else if (op_in == OP_EVAL && 32'(wheel_in) < WHEELS)
                    begin
                        n_next = cnt_reg[WB'(wheel_in)];
                        if (cnt_reg[WB'(wheel_in)] != '0)
                            state_next = S_RD;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_trial[32])
                begin
                    rem_next = div_trial;
                    quo_next = {quo_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift;
                    quo_next = {quo_reg[38:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd39)
                    state_next = S_WR;
            end
            S_WR:
            begin
                mem_we     = 1'b1;
                cnt_inc    = 1'b1;
                state_next = S_DONE;
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                f_next     = rd_q[67:36];
                ph_next    = rd_q[35:20];
                amp_next   = rd_q[19:0];
                state_next = S_MFT;
            end
            S_MFT:
            begin
                state_next = S_MZ;
            end
            S_MZ:
            begin
                quad_next  = u_ang[31:30];
                state_next = S_CST;
            end
            S_CST:
            begin
                cor_start  = 1'b1;
                state_next = S_CW;
            end
            S_CW:
            begin
                if (cor_done)
                begin
                    unique case (quad_reg)
                        2'd0:
                        begin
                            cos_next = cor_x;
                            sin_next = cor_y;
                        end
                        2'd1:
                        begin
                            cos_next = -cor_y;
                            sin_next = cor_x;
                        end
                        2'd2:
                        begin
                            cos_next = -cor_x;
                            sin_next = -cor_y;
                        end
                        default:
                        begin
                            cos_next = cor_y;
                            sin_next = -cor_x;
                        end
                    endcase
                    state_next = S_MH;
                end
            end
            S_MH:
            begin
                state_next = S_MAF;
            end
            S_MAF:
            begin
                hacc_next  = hacc_reg + HACC_W'(prod_reg >>> 30);
                state_next = S_MTP;
            end
            S_MTP:
            begin
                state_next = S_MV;
            end
            S_MV:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                vacc_next = vacc_reg + VACC_W'(prod_reg >>> 22);
                k_next    = k_reg + CB'(1);
                if (k_reg + CB'(1) == n_reg)
                    state_next = S_DONE;
                else
                    state_next = S_RD;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            speed_reg  <= '0;
            mvalid_reg <= 1'b0;
            for (int w = 0; w < WHEELS; w++)
                cnt_reg[w] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                speed_reg <= cfg_wdata;
            if (cnt_clr)
            begin
                for (int w = 0; w < WHEELS; w++)
                    cnt_reg[w] <= '0;
            end
            else if (cnt_inc)
                cnt_reg[widx] <= cnt_reg[widx] + CB'(1);
            if (state_reg == S_DONE && (!mvalid_reg || m_axis_tready))
                mvalid_reg <= 1'b1;
            else if (m_axis_tready)
                mvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        wheel_reg  <= wheel_next;
        amp_reg    <= amp_next;
        wl_reg     <= wl_next;
        ph_reg     <= ph_next;
        t_reg      <= t_next;
        f_reg      <= f_next;
        status_reg <= status_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        dcnt_reg   <= dcnt_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        quad_reg   <= quad_next;
        cos_reg    <= cos_next;
        sin_reg    <= sin_next;
        hacc_reg   <= hacc_next;
        vacc_reg   <= vacc_next;
        if (state_reg == S_DONE && (!mvalid_reg || m_axis_tready))
        begin
            oh_reg <= h_clamp[25:0];
            ov_reg <= v_clamp[39:0];
            os_reg <= status_reg;
        end
    end

    // harmonic store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {f_sat, ph_reg, amp_reg};
        rd_q <= mem[rd_addr];
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {4'b0, os_reg, ov_reg, oh_reg};

`ifndef SYNTHESIS
    a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> state_reg == S_CW)
        else $error("cordic finished outside its wait state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |-> cnt_reg[widx] < CB'(MAX_HARMONICS))
        else $error("harmonic written past wheel table end");

    a_eval_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> k_reg < n_reg)
        else $error("evaluation read beyond stored harmonics");
`endif

endmodule

>>> tb/sv/tb_road_harmonic_synthesizer.sv
// self-checking testbench of the per-wheel road harmonic synthesizer
`timescale 1ns / 1ps

module tb_road_harmonic_synthesizer;
    import rhs_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int N_WHEELS = 4;
    localparam int N_SLOTS = 16;
    localparam int ANGLE_W = 16;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  wheel;
        logic [19:0] amp;
        logic [31:0] wavelength;
        logic [15:0] phase;
        logic [31:0] t;
    } road_req_t;

    typedef struct packed {
        logic signed [25:0] height;
        logic signed [39:0] velocity;
        logic [1:0]         status;
    } road_sample_t;

    typedef struct {
        road_req_t    rq;
        bit           typed;
        road_sample_t want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    road_harmonic_synthesizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // arctangent of 2^-i in q30 radians
    longint atan_steps [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    // shadow of the harmonic tables and the speed register
    logic [19:0] amp_tab   [N_WHEELS][N_SLOTS];
    logic [15:0] phase_tab [N_WHEELS][N_SLOTS];
    logic [31:0] freq_tab  [N_WHEELS][N_SLOTS];
    int          harm_count [N_WHEELS];
    logic [15:0] speed;

    road_sample_t pending_samples [$];
    int           errors;
    bit           quiet;
    int           hold_left;
    longint       cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // road response of one request, updating the shadow tables
    function automatic road_sample_t road_response(input road_req_t rq);
        road_sample_t res;
        longint hsum, vsum, x, y, z, dx, dy, s, c, mag;
        longint unsigned f, prod;
        logic [31:0] u;
        int n;
        res = '0;
        hsum = 0;
        vsum = 0;
        case (rq.op)
            OP_CLEAR:
                foreach (harm_count[w])
                    harm_count[w] = 0;
            OP_ADD:
            begin
                if (rq.wavelength == 0)
                    res.status = ST_BAD_WAVE;
                else if (harm_count[rq.wheel] >= N_SLOTS)
                    res.status = ST_FULL;
                else
                begin
                    n = harm_count[rq.wheel];
                    f = (longint'(speed) << 24) / longint'(rq.wavelength);
                    if (f > 64'hFFFF_FFFF)
                        f = 64'hFFFF_FFFF;
                    amp_tab[rq.wheel][n] = rq.amp;
                    phase_tab[rq.wheel][n] = rq.phase;
                    freq_tab[rq.wheel][n] = f[31:0];
                    harm_count[rq.wheel] = n + 1;
                end
            end
            OP_EVAL:
            begin
                for (int k = 0; k < harm_count[rq.wheel]; k++)
                begin
                    f = freq_tab[rq.wheel][k];
                    prod = f * longint'(rq.t);
                    u = prod[31:0] + {phase_tab[rq.wheel][k], 16'd0};
                    u = u & (32'hFFFF_FFFF << (32 - ANGLE_W));
                    z = longint'((longint'(u[29:0]) * 64'd1686629713) >> 30);
                    x = 652032874;
                    y = 0;
                    for (int i = 0; i < 30; i++)
                    begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (z >= 0)
                        begin
                            x -= dx;
                            y += dy;
                            z -= atan_steps[i];
                        end
                        else
                        begin
                            x += dx;
                            y -= dy;
                            z += atan_steps[i];
                        end
                    end
                    // quadrant folding
                    case (u[31:30])
                        2'd0:    begin c = x;  s = y;  end
                        2'd1:    begin c = -y; s = x;  end
                        2'd2:    begin c = -x; s = -y; end
                        default: begin c = y;  s = -x; end
                    endcase
                    hsum += (longint'(amp_tab[rq.wheel][k]) * s) >>> 30;
                    prod = ((longint'(amp_tab[rq.wheel][k]) * f) >> 12) * 64'd6588397;
                    mag = longint'(prod >> 28);
                    vsum += (mag * (c >>> 8)) >>> 22;
                end
                if (hsum > 16777216)
                    hsum = 16777216;
                if (hsum < -16777216)
                    hsum = -16777216;
                if (vsum > 64'sd549755813887)
                    vsum = 64'sd549755813887;
                if (vsum < -64'sd549755813888)
                    vsum = -64'sd549755813888;
                res.height = hsum[25:0];
                res.velocity = vsum[39:0];
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // offer one request and log its expected sample once accepted
    task automatic issue_request(input road_req_t rq, input bit typed,
                                 input road_sample_t want);
        road_sample_t p;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tdata = {2'b00, rq.t, rq.phase, rq.wavelength, rq.amp, rq.wheel};
        s_axis_tuser = rq.op;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = road_response(rq);
        pending_samples.insert(pending_samples.size(), typed ? want : p);
        @(negedge clk);
    endtask

    // write the speed register while the block is idle
    task automatic set_speed(input logic [15:0] v);
        s_axis_tvalid = 1'b0;
        wait (pending_samples.size() == 0);
        repeat (5) @(negedge clk);
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        speed = v;
    endtask

    function automatic road_req_t rand_request();
        road_req_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq.op = pick < 4 ? OP_CLEAR : pick < 42 ? OP_ADD : pick < 94 ? OP_EVAL : OP_NOP;
        rq.wheel = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       rq.amp = 20'hFFFFF;
            1:       rq.amp = 20'h0;
            default: rq.amp = 20'($urandom);
        endcase
        if ($urandom_range(0, 30) == 0)
            rq.wavelength = 0;
        else
            rq.wavelength = $urandom >> $urandom_range(0, 31);
        rq.phase = 16'($urandom);
        rq.t = $urandom;
        return rq;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        road_sample_t got, exp_s;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.height = m_axis_tdata[25:0];
            got.velocity = m_axis_tdata[65:26];
            got.status = m_axis_tdata[67:66];
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample height %0d", $signed(got.height));
                errors++;
            end
            else
            begin
                exp_s = pending_samples.pop_front();
                if (got.height !== exp_s.height)
                begin
                    $error("height expected %0d got %0d", exp_s.height, got.height);
                    errors++;
                end
                if (got.velocity !== exp_s.velocity)
                begin
                    $error("vertical_velocity expected %0d got %0d",
                           exp_s.velocity, got.velocity);
                    errors++;
                end
                if (got.status !== exp_s.status)
                begin
                    $error("status expected %0d got %0d", exp_s.status, got.status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side backpressure, with a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        road_sample_t zero_s, bad_s, full_s;
        logic [15:0] phase_speeds [6];
        errors = 0;
        quiet = 1'b0;
        hold_left = 0;
        cycles = 0;
        speed = '0;
        foreach (harm_count[w])
            harm_count[w] = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NOP;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        zero_s = '0;
        bad_s = '0;
        bad_s.status = ST_BAD_WAVE;
        full_s = '0;
        full_s.status = ST_FULL;

        // directed table: empty wheel, op three, zero wavelength, extremes
        rows.insert(rows.size(), '{'{OP_EVAL, 2'd0, 20'd5, 32'd1, 16'd0, 32'd7}, 1, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_NOP, 2'd3, 20'hFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF},
                      1, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_ADD, 2'd1, 20'hFFFFF, 32'd0, 16'h1234, 32'd0}, 1, bad_s});
        rows.insert(rows.size(),
                    '{'{OP_ADD, 2'd0, 20'hFFFFF, 32'd1, 16'hFFFF, 32'd0}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_ADD, 2'd0, 20'd0, 32'hFFFFFFFF, 16'd0, 32'd0}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_ADD, 2'd3, 20'hFFFFF, 32'd65536, 16'd16384, 32'd0}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd0, 20'd0, 32'd0, 16'd0, 32'd0}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd0, 20'd0, 32'd0, 16'd0, 32'hFFFFFFFF}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd3, 20'd0, 32'd0, 16'd0, 32'd12345}, 0, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd1, 20'd0, 32'd0, 16'd0, 32'd99}, 1, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_CLEAR, 2'd2, 20'd3, 32'd3, 16'd3, 32'd3}, 1, zero_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd0, 20'd0, 32'd0, 16'd0, 32'd500}, 1, zero_s});
        // fill one wheel to the top, then one add too many
        for (int i = 0; i < N_SLOTS; i++)
            rows.insert(rows.size(),
                        '{'{OP_ADD, 2'd2, 20'hFFFFF, 32'd2 + i, 16'(i * 4096), 32'd0},
                          0, zero_s});
        rows.insert(rows.size(), '{'{OP_ADD, 2'd2, 20'd1, 32'd1, 16'd0, 32'd0}, 1, full_s});
        rows.insert(rows.size(),
                    '{'{OP_EVAL, 2'd2, 20'd0, 32'd0, 16'd0, 32'h00010000}, 0, zero_s});

        set_speed(16'hFFFF);
        foreach (rows[i])
        begin
            row = rows[i];
            issue_request(row.rq, row.typed, row.want);
        end

        // random phases over several speeds, extremes among them
        phase_speeds = '{16'd0, 16'd1, 16'hFFFF, 16'(256), 16'($urandom), 16'($urandom)};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_speed(phase_speeds[ph]);
            quiet = (ph == 5);
            for (int i = 0; i < 145; i++)
            begin
                // long result-side hold-off while requests keep coming
                if (ph == 1 && i == 20)
                    hold_left = 400;
                // sender drains everything before going on
                if (ph == 2 && i == 50)
                begin
                    s_axis_tvalid = 1'b0;
                    wait (pending_samples.size() == 0);
                    @(negedge clk);
                end
                issue_request(rand_request(), 0, zero_s);
            end
        end
        s_axis_tvalid = 1'b0;

        // drain
        wait (pending_samples.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
